/* rtl/dtes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_pkg - shared definitions of the distance triggered event sequencer
// Request and result types, request and register codes, controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dtes_pkg;

    localparam int unsigned DEF_ENTRIES = 8;
    localparam int unsigned TABLE_SLOTS = 8;

    localparam int unsigned REQ_W      = 3;
    localparam int unsigned POS_W      = 24;
    localparam int unsigned FUNC_W     = 4;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned DIST_W     = 8;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned THR_W      = POS_W + 2;
    localparam int unsigned FUNC_REG_W = FUNC_W * TABLE_SLOTS;
    localparam int unsigned ACT_REG_W  = ACT_W * TABLE_SLOTS;
    localparam int unsigned DIST_REG_W = DIST_W * TABLE_SLOTS;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [REQ_W-1:0] REQ_POSITION   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ARM_RESET  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_ARMED  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MAN_ENTER  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MAN_EXIT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_FUNC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_ACT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DIST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_FUNC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_ACT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DIST  = 3'd5;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [POS_W-1:0] position;
        logic                    trigger_value;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [FUNC_W-1:0] function_code;
        logic [ACT_W-1:0]  action_code;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_MARK
    } t_state;

    typedef struct packed {
        logic load_req;
        logic load_mask;
        logic set_armed;
        logic rearm;
        logic scan_step;
        logic emit_mark;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             armed;
        logic             pending;
        logic             idx_last;
        logic             out_free;
    } t_dp_status;

endpackage

/* rtl/distance_triggered_event_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_triggered_event_sequencer_core - distance triggered event sequencer
// Fires entry and exit table slots as a position approaches and leaves a
// turn line, with manual firing, re-arming and a finished marker.
// ----------------------------------------------------------------------------
// Results are registered, one per cycle at most. A firing request scans all
// ENTRIES table slots, one slot per cycle while the output register is free;
// a new request is taken only once the controller is back in idle.
// Reset: synchronous and active low; clears all registers but the request and
// result registers, marks every slot as fired and leaves the sequencer disarmed.
//
// The controller walks each request through decode, mask formation and a
// slot-by-slot scan. The datapath forms the firing mask of all slots at once
// from the registered request, then, while the output register is free, hands
// out one slot per cycle into it, so a new request can be taken while the last
// result of the previous one is still waiting downstream. The last flag of a
// result is known from the mask bits still left after the slot being emitted.
// Configuration writes are taken in every cycle and land directly in the
// datapath registers.
module distance_triggered_event_sequencer_core #(
    parameter int unsigned ENTRIES = dtes_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dtes_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dtes_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtes_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtes_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dtes_pkg::t_dp_cmd    w_cmd;
    dtes_pkg::t_dp_status w_status;

    // The register file never stalls a write request.
    assign o_cfg_ready = 1'b1;

    dtes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dtes_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/dtes_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_ctrl - sequencer controller
// Decodes each request and steps the datapath through its table scan.
// ----------------------------------------------------------------------------
module dtes_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dtes_pkg::t_dp_status i_status,
    output dtes_pkg::t_dp_cmd    o_cmd
);

    dtes_pkg::t_state r_state;
    dtes_pkg::t_state n_state;

    logic w_is_pos;
    logic w_is_manual;

    assign w_is_pos    = (i_status.req_type == dtes_pkg::REQ_POSITION);
    assign w_is_manual = (i_status.req_type == dtes_pkg::REQ_MAN_ENTER) ||
                         (i_status.req_type == dtes_pkg::REQ_MAN_EXIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtes_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtes_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dtes_pkg::ST_EVAL;
                end
            end
            dtes_pkg::ST_EVAL: begin
                priority if (w_is_pos && !i_status.armed) begin
                    n_state = dtes_pkg::ST_IDLE;
                end else if (w_is_pos && !i_status.pending) begin
                    n_state = dtes_pkg::ST_MARK;
                end else if (w_is_pos || w_is_manual) begin
                    n_state = dtes_pkg::ST_SCAN;
                end else begin
                    n_state = dtes_pkg::ST_IDLE;
                end
            end
            dtes_pkg::ST_SCAN: begin
                if (i_status.out_free && i_status.idx_last) begin
                    n_state = dtes_pkg::ST_IDLE;
                end
            end
            dtes_pkg::ST_MARK: begin
                if (i_status.out_free) begin
                    n_state = dtes_pkg::ST_IDLE;
                end
            end
            default: n_state = dtes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dtes_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            dtes_pkg::ST_EVAL: begin
                o_cmd.rearm     = (i_status.req_type == dtes_pkg::REQ_ARM_RESET);
                o_cmd.set_armed = (i_status.req_type == dtes_pkg::REQ_SET_ARMED);
                o_cmd.load_mask = w_is_manual ||
                                  (w_is_pos && i_status.armed && i_status.pending);
            end
            dtes_pkg::ST_SCAN: begin
                o_cmd.scan_step = i_status.out_free;
                o_cmd.rearm     = i_status.out_free && i_status.idx_last && w_is_manual;
            end
            dtes_pkg::ST_MARK: begin
                o_cmd.emit_mark = i_status.out_free;
                o_cmd.rearm     = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/dtes_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_datapath - tables, fired marks and result register
// Holds the configuration, the fired marks and the armed flag, forms the
// firing mask of a request and walks it one slot per step.
// ----------------------------------------------------------------------------
module dtes_datapath #(
    parameter int unsigned ENTRIES = dtes_pkg::DEF_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtes_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    input  logic [dtes_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dtes_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    input  dtes_pkg::t_dp_cmd                   i_cmd,
    output dtes_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output dtes_pkg::t_out_item                 o_out_item
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [dtes_pkg::FUNC_REG_W-1:0] r_en_func, n_en_func, r_ex_func, n_ex_func;
    logic [dtes_pkg::ACT_REG_W-1:0]  r_en_act,  n_en_act,  r_ex_act,  n_ex_act;
    logic [dtes_pkg::DIST_REG_W-1:0] r_en_dist, n_en_dist, r_ex_dist, n_ex_dist;

    logic [ENTRIES-1:0] r_en_fired, n_en_fired;
    logic [ENTRIES-1:0] r_ex_fired, n_ex_fired;
    logic               r_armed, n_armed;
    dtes_pkg::t_in_item r_req, n_req;
    logic [ENTRIES-1:0] r_mask, n_mask;
    logic               r_sel_exit, n_sel_exit;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    dtes_pkg::t_out_item r_out, n_out;

    logic [dtes_pkg::FUNC_W-1:0]      w_en_fn  [ENTRIES];
    logic [dtes_pkg::FUNC_W-1:0]      w_ex_fn  [ENTRIES];
    logic [dtes_pkg::ACT_W-1:0]       w_en_ac  [ENTRIES];
    logic [dtes_pkg::ACT_W-1:0]       w_ex_ac  [ENTRIES];
    logic signed [dtes_pkg::THR_W-1:0] w_en_thr [ENTRIES];
    logic signed [dtes_pkg::THR_W-1:0] w_ex_thr [ENTRIES];

    logic signed [dtes_pkg::THR_W-1:0] w_pos;
    logic signed [dtes_pkg::THR_W-1:0] w_neg;
    logic                              w_pos_le0;
    logic [ENTRIES-1:0]                w_en_hit;
    logic [ENTRIES-1:0]                w_ex_hit;
    logic [ENTRIES-1:0]                w_bit;
    logic [ENTRIES-1:0]                w_mask_left;
    logic                              w_out_free;

    // Slots beyond the register layout read as disabled with zero fields.
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_slot
        if (gi < dtes_pkg::TABLE_SLOTS) begin : g_real
            logic [dtes_pkg::DIST_W-1:0] w_dn;
            logic [dtes_pkg::DIST_W-1:0] w_dx;
            assign w_dn = r_en_dist[gi*dtes_pkg::DIST_W +: dtes_pkg::DIST_W];
            assign w_dx = r_ex_dist[gi*dtes_pkg::DIST_W +: dtes_pkg::DIST_W];
            assign w_en_fn[gi] = r_en_func[gi*dtes_pkg::FUNC_W +: dtes_pkg::FUNC_W];
            assign w_ex_fn[gi] = r_ex_func[gi*dtes_pkg::FUNC_W +: dtes_pkg::FUNC_W];
            assign w_en_ac[gi] = r_en_act[gi*dtes_pkg::ACT_W +: dtes_pkg::ACT_W];
            assign w_ex_ac[gi] = r_ex_act[gi*dtes_pkg::ACT_W +: dtes_pkg::ACT_W];
            assign w_en_thr[gi] = {{(dtes_pkg::THR_W-dtes_pkg::DIST_W-dtes_pkg::FRAC_W)
                                    {w_dn[dtes_pkg::DIST_W-1]}},
                                   w_dn, {dtes_pkg::FRAC_W{1'b0}}};
            assign w_ex_thr[gi] = {{(dtes_pkg::THR_W-dtes_pkg::DIST_W-dtes_pkg::FRAC_W)
                                    {w_dx[dtes_pkg::DIST_W-1]}},
                                   w_dx, {dtes_pkg::FRAC_W{1'b0}}};
        end else begin : g_none
            assign w_en_fn[gi]  = '0;
            assign w_ex_fn[gi]  = '0;
            assign w_en_ac[gi]  = '0;
            assign w_ex_ac[gi]  = '0;
            assign w_en_thr[gi] = '0;
            assign w_ex_thr[gi] = '0;
        end
    end

    assign w_pos = {{(dtes_pkg::THR_W-dtes_pkg::POS_W){r_req.position[dtes_pkg::POS_W-1]}},
                    r_req.position};
    assign w_neg     = -w_pos;
    assign w_pos_le0 = r_req.position[dtes_pkg::POS_W-1] || (r_req.position == '0);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_en_hit[i] = !r_en_fired[i] && (w_neg >= w_en_thr[i]);
            w_ex_hit[i] = !r_ex_fired[i] && (w_pos <= w_ex_thr[i]);
        end
    end

    assign w_bit       = {{(ENTRIES-1){1'b0}}, 1'b1} << r_idx;
    assign w_mask_left = r_mask & ~w_bit;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_en_func   = r_en_func;
        n_en_act    = r_en_act;
        n_en_dist   = r_en_dist;
        n_ex_func   = r_ex_func;
        n_ex_act    = r_ex_act;
        n_ex_dist   = r_ex_dist;
        n_en_fired  = r_en_fired;
        n_ex_fired  = r_ex_fired;
        n_armed     = r_armed;
        n_req       = r_req;
        n_mask      = r_mask;
        n_sel_exit  = r_sel_exit;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dtes_pkg::CFG_ENTER_FUNC: n_en_func = i_cfg_data[dtes_pkg::FUNC_REG_W-1:0];
                dtes_pkg::CFG_ENTER_ACT:  n_en_act  = i_cfg_data[dtes_pkg::ACT_REG_W-1:0];
                dtes_pkg::CFG_ENTER_DIST: n_en_dist = i_cfg_data[dtes_pkg::DIST_REG_W-1:0];
                dtes_pkg::CFG_EXIT_FUNC:  n_ex_func = i_cfg_data[dtes_pkg::FUNC_REG_W-1:0];
                dtes_pkg::CFG_EXIT_ACT:   n_ex_act  = i_cfg_data[dtes_pkg::ACT_REG_W-1:0];
                dtes_pkg::CFG_EXIT_DIST:  n_ex_dist = i_cfg_data[dtes_pkg::DIST_REG_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load_req) begin
            n_req = i_in_item;
        end

        if (i_cmd.set_armed) begin
            n_armed = r_req.trigger_value;
        end

        if (i_cmd.load_mask) begin
            unique case (r_req.req_type)
                dtes_pkg::REQ_POSITION: begin
                    n_mask     = w_pos_le0 ? w_en_hit : w_ex_hit;
                    n_sel_exit = !w_pos_le0;
                end
                dtes_pkg::REQ_MAN_ENTER: begin
                    n_mask     = ~r_en_fired;
                    n_sel_exit = 1'b0;
                end
                dtes_pkg::REQ_MAN_EXIT: begin
                    n_mask     = ~r_ex_fired;
                    n_sel_exit = 1'b1;
                end
                default: begin
                    n_mask     = '0;
                    n_sel_exit = 1'b0;
                end
            endcase
        end

        if (i_cmd.scan_step) begin
            n_idx = (r_idx == IDX_W'(ENTRIES - 1)) ? '0 : r_idx + 1'b1;
            if (r_mask[r_idx]) begin
                n_mask                  = w_mask_left;
                n_out_valid             = 1'b1;
                n_out.kind              = dtes_pkg::KIND_EVENT;
                n_out.last              = (w_mask_left == '0);
                if (r_sel_exit) begin
                    n_ex_fired[r_idx]   = 1'b1;
                    n_out.function_code = w_ex_fn[r_idx];
                    n_out.action_code   = w_ex_ac[r_idx];
                end else begin
                    n_en_fired[r_idx]   = 1'b1;
                    n_out.function_code = w_en_fn[r_idx];
                    n_out.action_code   = w_en_ac[r_idx];
                end
            end
        end

        if (i_cmd.emit_mark) begin
            n_out_valid         = 1'b1;
            n_out.kind          = dtes_pkg::KIND_FINISH;
            n_out.function_code = '0;
            n_out.action_code   = '0;
            n_out.last          = 1'b1;
        end

        // Re-arming comes after any firing of the same cycle.
        if (i_cmd.rearm) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_en_fn[i] != '0) begin
                    n_en_fired[i] = 1'b0;
                end
                if (w_ex_fn[i] != '0) begin
                    n_ex_fired[i] = 1'b0;
                end
            end
            n_armed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_func   <= '0;
            r_en_act    <= '0;
            r_en_dist   <= '0;
            r_ex_func   <= '0;
            r_ex_act    <= '0;
            r_ex_dist   <= '0;
            r_en_fired  <= '1;
            r_ex_fired  <= '1;
            r_armed     <= 1'b0;
            r_mask      <= '0;
            r_sel_exit  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_en_func   <= n_en_func;
            r_en_act    <= n_en_act;
            r_en_dist   <= n_en_dist;
            r_ex_func   <= n_ex_func;
            r_ex_act    <= n_ex_act;
            r_ex_dist   <= n_ex_dist;
            r_en_fired  <= n_en_fired;
            r_ex_fired  <= n_ex_fired;
            r_armed     <= n_armed;
            r_mask      <= n_mask;
            r_sel_exit  <= n_sel_exit;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    assign o_status.req_type = r_req.req_type;
    assign o_status.armed    = r_armed;
    assign o_status.pending  = !(&r_en_fired) || !(&r_ex_fired);
    assign o_status.idx_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/dtes_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_checker - port level checks of the event sequencer
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module dtes_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input dtes_pkg::t_out_item             o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result presented straight after reset");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == dtes_pkg::KIND_FINISH) |->
            o_out_item.last && (o_out_item.function_code == '0) &&
            (o_out_item.action_code == '0))
        else $error("finished marker malformed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is being decoded");

endmodule

bind distance_triggered_event_sequencer_core dtes_checker u_dtes_checker (.*);
